FILE: rtl/core/gpow_pkg.sv
// Package for the GF(2) generator power block.
// Holds the configuration register map, port widths and pipeline constants.
// No dependencies.
`default_nettype none

package gpow_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ExpInW   = 16;
  localparam int unsigned PowerW   = 16;
  localparam int unsigned DegRegW  = 5;

  // Horner steps handled by one pipeline stage.
  localparam int unsigned StepsPerStage = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODULUS   = 2'd0,
    CFG_DEGREE    = 2'd1,
    CFG_SINGLETON = 2'd2
  } cfg_reg_e;

  localparam logic [CfgDataW-1:0] ModulusRst   = 16'd11;
  localparam logic [DegRegW-1:0]  DegreeRst    = 5'd3;
  localparam logic [CfgDataW-1:0] SingletonRst = 16'd7;

endpackage

`default_nettype wire

FILE: rtl/core/gpow_cfg.sv
// Configuration registers of the GF(2) generator power block.
// Derives the effective degree, degree mask and reduction terms.
// Depends on gpow_pkg.
`default_nettype none

module gpow_cfg
  import gpow_pkg::*;
#(
  parameter  int MAX_DEGREE = 16,
  parameter  int EXP_WIDTH  = 16,
  localparam int DegW       = $clog2(MAX_DEGREE + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [CfgDataW-1:0]   cfg_data_i,
  output      logic [DegW-1:0]       degree_o,
  output      logic                  degree_zero_o,
  output      logic [MAX_DEGREE-1:0] mask_o,
  output      logic [MAX_DEGREE-1:0] low_o,
  output      logic [EXP_WIDTH-1:0]  singleton_o
);

  logic [CfgDataW-1:0] modulus_q, modulus_d;
  logic [DegRegW-1:0]  degree_q, degree_d;
  logic [CfgDataW-1:0] singleton_q, singleton_d;
  logic [31:0]         modulus_wide;
  logic [31:0]         singleton_wide;

  always_comb begin
    modulus_d   = modulus_q;
    degree_d    = degree_q;
    singleton_d = singleton_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_MODULUS:   modulus_d   = cfg_data_i;
        CFG_DEGREE:    degree_d    = cfg_data_i[DegRegW-1:0];
        CFG_SINGLETON: singleton_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= ModulusRst;
      degree_q    <= DegreeRst;
      singleton_q <= SingletonRst;
    end else begin
      modulus_q   <= modulus_d;
      degree_q    <= degree_d;
      singleton_q <= singleton_d;
    end
  end

  always_comb begin
    if (32'(degree_q) > MAX_DEGREE) begin
      degree_o = DegW'(MAX_DEGREE);
    end else begin
      degree_o = DegW'(degree_q);
    end
    degree_zero_o = (degree_o == '0);
    for (int i = 0; i < MAX_DEGREE; i++) begin
      mask_o[i] = (DegW'(i) < degree_o);
    end
    modulus_wide   = 32'(modulus_q);
    low_o          = modulus_wide[MAX_DEGREE-1:0] & mask_o;
    singleton_wide = 32'(singleton_q);
    singleton_o    = singleton_wide[EXP_WIDTH-1:0];
  end

endmodule

`default_nettype wire

FILE: rtl/core/gpow_stage.sv
// One pipeline stage of the square-and-multiply unit.
// Runs a slice of Horner steps of the modular squaring and, in the last slice
// of an exponent bit, the conditional multiply by x. Depends on gpow_pkg.
`default_nettype none

module gpow_stage
  import gpow_pkg::*;
#(
  parameter  int MAX_DEGREE = 16,
  parameter  int EXP_WIDTH  = 16,
  parameter  int HI         = 15,
  parameter  int LO         = 8,
  parameter  int EBIT       = 15,
  localparam int DegW       = $clog2(MAX_DEGREE + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [DegW-1:0]       degree_i,
  input  wire logic [MAX_DEGREE-1:0] mask_i,
  input  wire logic [MAX_DEGREE-1:0] low_i,
  input  wire logic                  vld_i,
  output      logic                  rdy_o,
  input  wire logic [MAX_DEGREE-1:0] acc_i,
  input  wire logic [MAX_DEGREE-1:0] opnd_i,
  input  wire logic [EXP_WIDTH-1:0]  exp_i,
  input  wire logic                  zero_i,
  output      logic                  vld_o,
  input  wire logic                  rdy_i,
  output      logic [MAX_DEGREE-1:0] acc_o,
  output      logic [MAX_DEGREE-1:0] opnd_o,
  output      logic [EXP_WIDTH-1:0]  exp_o,
  output      logic                  zero_o
);

  logic                  vld_q, vld_d;
  logic [MAX_DEGREE-1:0] acc_q, acc_d;
  logic [MAX_DEGREE-1:0] opnd_q, opnd_d;
  logic [EXP_WIDTH-1:0]  exp_q;
  logic                  zero_q;
  logic                  load;

  function automatic logic [MAX_DEGREE-1:0] times_x(
    input logic [MAX_DEGREE-1:0] r,
    input logic [DegW-1:0]       d,
    input logic [MAX_DEGREE-1:0] low,
    input logic [MAX_DEGREE-1:0] mask
  );
    logic [MAX_DEGREE:0]   t;
    logic [MAX_DEGREE-1:0] s;
    t = {r, 1'b0};
    s = t[MAX_DEGREE-1:0];
    if (t[d]) begin
      s = s ^ low;
    end
    return s & mask;
  endfunction

  always_comb begin
    logic [MAX_DEGREE-1:0] a;
    a = acc_i;
    for (int k = 0; k <= HI - LO; k++) begin
      a = times_x(a, degree_i, low_i, mask_i);
      if (opnd_i[HI-k]) begin
        a = a ^ opnd_i;
      end
    end
    if (LO == 0) begin
      if (exp_i[EBIT]) begin
        a = times_x(a, degree_i, low_i, mask_i);
      end
      opnd_d = a;
      acc_d  = '0;
    end else begin
      opnd_d = opnd_i;
      acc_d  = a;
    end
  end

  assign rdy_o = !vld_q || rdy_i;
  assign load  = rdy_o && vld_i;
  assign vld_d = rdy_o ? vld_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      acc_q  <= acc_d;
      opnd_q <= opnd_d;
      exp_q  <= exp_i;
      zero_q <= zero_i;
    end
  end

  assign vld_o  = vld_q;
  assign acc_o  = acc_q;
  assign opnd_o = opnd_q;
  assign exp_o  = exp_q;
  assign zero_o = zero_q;

endmodule

`default_nettype wire

FILE: rtl/core/gf2_generator_power.sv
// Throughput: one word per cycle; each exponent bit takes ceil(MAX_DEGREE / 8) stages
// of eight Horner steps of the modular squaring, and stalls only hold a full pipeline.
// Reset clears every stage valid bit and loads the register defaults
// (modulus terms 11, degree 3, singleton index 7). Depends on gpow_pkg.
`default_nettype none

module gf2_generator_power
  import gpow_pkg::*;
#(
  parameter int MAX_DEGREE = 16,
  parameter int EXP_WIDTH  = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [ExpInW-1:0]   s_axis_tdata,   // [15:0] exponent_index
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [PowerW-1:0]   m_axis_tdata,   // [15:0] power_value
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int DegW   = $clog2(MAX_DEGREE + 1);
  localparam int Chunks = (MAX_DEGREE + StepsPerStage - 1) / StepsPerStage;
  localparam int NumSt  = EXP_WIDTH * Chunks;

  logic [DegW-1:0]       degree;
  logic                  degree_zero;
  logic [MAX_DEGREE-1:0] mask;
  logic [MAX_DEGREE-1:0] low;
  logic [EXP_WIDTH-1:0]  singleton;

  logic                  st_vld  [NumSt+1];
  logic                  st_rdy  [NumSt+1];
  logic [MAX_DEGREE-1:0] st_acc  [NumSt+1];
  logic [MAX_DEGREE-1:0] st_opnd [NumSt+1];
  logic [EXP_WIDTH-1:0]  st_exp  [NumSt+1];
  logic                  st_zero [NumSt+1];

  logic [31:0] exp_wide;
  logic [31:0] power_wide;
  logic [NumSt-1:0] vld_vec;

  gpow_cfg #(
    .MAX_DEGREE(MAX_DEGREE),
    .EXP_WIDTH (EXP_WIDTH)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .degree_o     (degree),
    .degree_zero_o(degree_zero),
    .mask_o       (mask),
    .low_o        (low),
    .singleton_o  (singleton)
  );

  assign exp_wide   = 32'(s_axis_tdata);
  assign st_vld[0]  = s_axis_tvalid;
  assign st_acc[0]  = '0;
  assign st_opnd[0] = MAX_DEGREE'(1);
  assign st_exp[0]  = exp_wide[EXP_WIDTH-1:0];
  assign st_zero[0] = degree_zero || (exp_wide[EXP_WIDTH-1:0] == singleton);
  assign s_axis_tready = st_rdy[0];

  for (genvar j = 0; j < NumSt; j++) begin : g_stage
    localparam int It = j / Chunks;
    localparam int Ch = j % Chunks;
    localparam int Hi = MAX_DEGREE - 1 - StepsPerStage * Ch;
    localparam int Lo = (Hi - StepsPerStage + 1 > 0) ? Hi - StepsPerStage + 1 : 0;

    gpow_stage #(
      .MAX_DEGREE(MAX_DEGREE),
      .EXP_WIDTH (EXP_WIDTH),
      .HI        (Hi),
      .LO        (Lo),
      .EBIT      (EXP_WIDTH - 1 - It)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .degree_i(degree),
      .mask_i  (mask),
      .low_i   (low),
      .vld_i   (st_vld[j]),
      .rdy_o   (st_rdy[j]),
      .acc_i   (st_acc[j]),
      .opnd_i  (st_opnd[j]),
      .exp_i   (st_exp[j]),
      .zero_i  (st_zero[j]),
      .vld_o   (st_vld[j+1]),
      .rdy_i   (st_rdy[j+1]),
      .acc_o   (st_acc[j+1]),
      .opnd_o  (st_opnd[j+1]),
      .exp_o   (st_exp[j+1]),
      .zero_o  (st_zero[j+1])
    );

    assign vld_vec[j] = st_vld[j+1];
  end

  assign st_rdy[NumSt] = m_axis_tready;
  assign m_axis_tvalid = st_vld[NumSt];
  assign power_wide    = 32'(st_opnd[NumSt]);
  assign m_axis_tdata  = st_zero[NumSt] ? '0 : power_wide[PowerW-1:0];

`ifndef SYNTHESIS
  a_accept_loads_first_stage : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_vec[0]
  ) else $error("accepted word did not reach the first stage");

  a_full_stall_blocks_input : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ((&vld_vec) && !m_axis_tready) |-> !s_axis_tready
  ) else $error("input accepted while the pipeline is full and stalled");

  a_stalled_output_held : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(st_opnd[NumSt])
                                           && $stable(st_zero[NumSt]))
  ) else $error("last stage changed while stalled");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_gf2_generator_power.sv
// Self-checking testbench for gf2_generator_power: streams exponent words through the
// block under several modulus, degree and singleton settings and checks each power word.
// Depends on gpow_pkg and the gf2_generator_power RTL.
`default_nettype none

module tb_gf2_generator_power;
  import gpow_pkg::*;

  localparam int unsigned MaxDegree      = 16;
  localparam int unsigned IdlePercent    = 22;
  localparam int unsigned HoldCycles     = 300;
  localparam int unsigned WatchdogLimit  = 4000;
  localparam int unsigned DrainCycles    = 64;
  localparam int unsigned NumPhases      = 12;
  localparam int unsigned WordsPerPhase  = 145;
  localparam int unsigned QuietPhase     = 6;
  localparam logic [CfgIdxW-1:0] CfgUnmappedIdx = 2'd3;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ExpInW-1:0]   s_axis_tdata  = '0;  // [15:0] exponent_index
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [PowerW-1:0]   m_axis_tdata;        // [15:0] power_value
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  logic [CfgDataW-1:0] cfg_modulus   = ModulusRst;
  logic [DegRegW-1:0]  cfg_degree    = DegreeRst;
  logic [CfgDataW-1:0] cfg_singleton = SingletonRst;

  logic [ExpInW-1:0] pending_exponents[$];
  logic [PowerW-1:0] expected_powers[$];

  int unsigned n_words_in   = 0;
  int unsigned n_results    = 0;
  int unsigned n_mismatch   = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned idle_cycles  = 0;
  int unsigned hold_left    = 0;
  logic        hold_arm     = 1'b0;
  logic        hold_fired   = 1'b0;
  logic        no_idle      = 1'b0;

  gf2_generator_power u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] poly_times_x(input logic [31:0] r, input int unsigned deg,
                                               input logic [31:0] low, input logic [31:0] dmask);
    logic [31:0] t;
    t = r << 1;
    if (t[deg]) t ^= low;
    return t & dmask;
  endfunction

  function automatic logic [PowerW-1:0] gf2_x_power(input logic [ExpInW-1:0] e);
    int unsigned deg;
    logic [31:0] dmask, low, r, sq;
    deg = cfg_degree;
    if (deg > MaxDegree) deg = MaxDegree;
    if (e == cfg_singleton || deg == 0) return '0;
    dmask = (32'd1 << deg) - 32'd1;
    low   = {16'b0, cfg_modulus} & dmask;
    r     = 32'd1;
    for (int i = ExpInW - 1; i >= 0; i--) begin
      sq = '0;
      for (int j = int'(deg) - 1; j >= 0; j--) begin
        sq = poly_times_x(sq, deg, low, dmask);
        if (r[j]) sq ^= r;
      end
      r = sq & dmask;
      if (e[i]) r = poly_times_x(r, deg, low, dmask);
    end
    return r[PowerW-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [PowerW-1:0] got,
                                 input logic [PowerW-1:0] want);
    $display("MISMATCH result %0d: %s got 0x%04h expected 0x%04h", n_results, what, got, want);
    n_mismatch++;
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_MODULUS:   cfg_modulus   = data;
      CFG_DEGREE:    cfg_degree    = data[DegRegW-1:0];
      CFG_SINGLETON: cfg_singleton = data;
      default: ;
    endcase
    n_cfg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drain();
    do @(negedge clk_i);
    while (pending_exponents.size() != 0 || s_axis_tvalid || expected_powers.size() != 0);
  endtask

  function automatic logic [ExpInW-1:0] pick_exponent();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return cfg_singleton;
    if (pick < 18) return ExpInW'($urandom_range(0, 31));
    if (pick < 22) return (pick[0]) ? '1 : '0;
    return ExpInW'($urandom());
  endfunction

  always @(posedge clk_i) begin : drive_proc
    logic fire;
    fire = s_axis_tvalid && s_axis_tready;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        expected_powers.push_back(gf2_x_power(s_axis_tdata));
        n_words_in++;
      end
      if (!s_axis_tvalid || fire) begin
        if (pending_exponents.size() != 0 &&
            (no_idle || $urandom_range(0, 99) >= IdlePercent)) begin
          s_axis_tdata  <= pending_exponents.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : sink_proc
    logic [PowerW-1:0] want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (expected_powers.size() == 0) begin
          report_mismatch("unexpected word,", m_axis_tdata, '0);
        end else begin
          want = expected_powers.pop_front();
          if (m_axis_tdata !== want) report_mismatch("power_value", m_axis_tdata, want);
        end
      end
      m_axis_tready <= (hold_left == 0) && (no_idle || $urandom_range(0, 99) >= IdlePercent);
    end
  end

  always @(posedge clk_i) begin : hold_proc
    if (hold_arm && !hold_fired) begin
      hold_left  <= HoldCycles;
      hold_fired <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin : watchdog_proc
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim_proc
    logic [CfgDataW-1:0] modulus, singleton;
    logic [DegRegW-1:0]  degree;
    logic [ExpInW-1:0]   directed_exps[$];
    directed_exps = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd6, 16'd7, 16'd8, 16'd14, 16'd15,
                      16'd16, 16'hFFFF, 16'hFFFE, 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555,
                      16'h00FF, 16'hFF00, 16'h0007, 16'h1234};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed_exps[k]) pending_exponents.push_back(directed_exps[k]);
    wait_drain();

    // With the singleton at zero the exponent-zero word must read back as zero too.
    write_cfg(CFG_SINGLETON, '0);
    @(negedge clk_i);
    pending_exponents.push_back('0);
    pending_exponents.push_back(16'd7);
    wait_drain();

    for (int phase = 0; phase < NumPhases; phase++) begin
      modulus   = CfgDataW'($urandom());
      singleton = CfgDataW'($urandom());
      degree    = ($urandom_range(0, 4) == 0) ? DegRegW'($urandom_range(0, 31))
                                              : DegRegW'($urandom_range(1, 16));
      case (phase)
        0: begin modulus = 16'h002D; degree = 5'd16; singleton = '0;    end
        1: begin modulus = '0;       degree = 5'd1;  singleton = '1;    end
        2: begin modulus = '1;       degree = 5'd1;  singleton = 16'd1; end
        3: degree = 5'd0;
        4: begin modulus = '1;       degree = 5'd31; singleton = '1;    end
        5: degree = 5'd17;
        6: begin modulus = 16'hFF1D; degree = 5'd8;                     end
        7: begin modulus = 16'd3;    degree = 5'd2;                     end
        default: ;
      endcase
      write_cfg(CFG_MODULUS, modulus);
      write_cfg(CFG_DEGREE, {(CfgDataW - DegRegW)'($urandom()), degree});
      write_cfg(CFG_SINGLETON, singleton);
      write_cfg(CfgUnmappedIdx, CfgDataW'($urandom()));
      @(negedge clk_i);
      no_idle = (phase == QuietPhase);
      for (int n = 0; n < WordsPerPhase; n++) pending_exponents.push_back(pick_exponent());
      if (phase == QuietPhase) hold_arm = 1'b1;
      wait_drain();
      no_idle = 1'b0;
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("Run covered %0d exponent words and %0d results over %0d register writes,",
             n_words_in, n_results, n_cfg_writes);
    $display("including degrees 0, 1, 16 and above, singleton hits and a long output stall.");
    if (n_mismatch == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
